// ===== src/ost_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared widths, operation codes and controller/datapath structs.
package ost_pkg;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;    // latch request, clear result flag
    logic insert;  // append value at the count, bump the count
    logic start;   // read entry 0, index to 0
    logic step;    // advance search index
    logic shift;   // move entry idx+1 down to idx, advance index
    logic drop;    // decrement count, flag success
    logic hit;     // flag found
    logic post;    // load result register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    func_t func;
    logic  full;
    logic  empty;
    logic  match;
    logic  last;
    logic  out_free;
  } sts_t;

endpackage

// ===== src/ost_if.sv =====
`timescale 1ns / 1ps
// Interfaces: request and response channels.
interface ost_req_if;
  logic                               valid;
  logic                               ready;
  logic        [ost_pkg::FUNC_W-1:0]  func;
  logic signed [ost_pkg::VALUE_W-1:0] item_value;

  modport source(output valid, func, item_value, input ready);
  modport sink(input valid, func, item_value, output ready);
endinterface

interface ost_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [ost_pkg::COUNT_W-1:0] entry_count;

  modport source(output valid, ok, entry_count, input ready);
  modport sink(input valid, ok, entry_count, output ready);
endinterface

// ===== src/ost_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ost_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ost_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: request latch, count, walk index, entry RAM and result register.
module ost_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ost_pkg::cmd_t                       cmd,
  output ost_pkg::sts_t                       sts,
  input  logic        [ost_pkg::FUNC_W-1:0]   in_func,
  input  logic signed [ost_pkg::VALUE_W-1:0]  in_item_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ok,
  output logic        [ost_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int VW   = ost_pkg::VALUE_W;
  localparam int OutW = ost_pkg::COUNT_W;

  ost_pkg::func_t      func_r;
  logic [VW-1:0]       value_r;
  logic                ok_r, ok_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       idx_inc;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r;
  logic [OutW-1:0]     out_count_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [VW-1:0]       ram_wdata, ram_rdata;

  assign idx_inc = CW'(idx_r) + CW'(1);

  always_comb begin
    ram_we    = cmd.insert | cmd.shift;
    ram_waddr = cmd.insert ? AW'(count_r) : idx_r;
    ram_wdata = cmd.insert ? value_r : ram_rdata;
    if (cmd.start) begin
      ram_raddr = '0;
    end else if (cmd.shift) begin
      ram_raddr = AW'(idx_inc + CW'(1));
    end else begin
      ram_raddr = AW'(idx_inc);
    end
  end

  ost_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ok_nxt        = ok_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      ok_nxt = 1'b0;
    end
    if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
      ok_nxt    = 1'b1;
    end
    if (cmd.drop) begin
      count_nxt = count_r - CW'(1);
      ok_nxt    = 1'b1;
    end
    if (cmd.hit) begin
      ok_nxt = 1'b1;
    end
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.step || cmd.shift) begin
      idx_nxt = AW'(idx_inc);
    end
    if (cmd.post) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r        <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ok_r        <= ok_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= ost_pkg::func_t'(in_func);
      value_r <= in_item_value;
    end
    if (cmd.post) begin
      out_ok_r    <= ok_r;
      out_count_r <= OutW'(count_r);
    end
  end

  assign sts.func     = func_r;
  assign sts.full     = (count_r == CW'(CAPACITY));
  assign sts.empty    = (count_r == '0);
  assign sts.match    = (ram_rdata == value_r);
  assign sts.last     = (idx_inc >= count_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_entry_count = out_count_r;

endmodule

// ===== src/ost_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences insert, search and compaction for one transaction.
module ost_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ost_pkg::sts_t sts,
  output ost_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SEARCH   = 5'b00100,
    S_SHIFT    = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        unique case (sts.func) inside
          ost_pkg::FUNC_INSERT: begin
            cmd.insert = !sts.full;
          end
          ost_pkg::FUNC_REMOVE, ost_pkg::FUNC_QUERY: begin
            if (!sts.empty) begin
              cmd.start = 1'b1;
              state_nxt = S_SEARCH;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SEARCH: begin
        if (sts.match) begin
          if (sts.func == ost_pkg::FUNC_REMOVE) begin
            state_nxt = S_SHIFT;
          end else begin
            cmd.hit   = 1'b1;
            state_nxt = S_FINISH;
          end
        end else if (sts.last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.last) begin
          cmd.drop  = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/ordered_set_table_unit.sv =====
`timescale 1ns / 1ps
// Ordered set table: insertion-ordered list with insert, remove and query.
// Insert or unused code: latch, dispatch, post result. Query and remove also search
// the stored entries, one RAM read per step; remove then shifts later entries down.
// Throughput: one transaction in flight; the next request is taken once the
// result is in the output register, even while it waits to be taken.
// Reset (synchronous, rst_n low): count zero, controller idle, no result pending.
module ordered_set_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  ost_req_if.sink      in_req,
  ost_rsp_if.source    out_rsp
);

  ost_pkg::cmd_t cmd;
  ost_pkg::sts_t sts;
  logic          in_ready;

  ost_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ost_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_req.func),
    .in_item_value   (in_req.item_value),
    .out_valid       (out_rsp.valid),
    .out_ready       (out_rsp.ready),
    .out_ok          (out_rsp.ok),
    .out_entry_count (out_rsp.entry_count)
  );

  assign in_req.ready = in_ready;

endmodule
